FILE: rtl/core/bsc_pkg.sv
// shared types, constants and helpers for the balance and speed cascade
package bsc_pkg;

    // field and datapath widths
    localparam int GAIN_W    = 24;
    localparam int ANGLE_W   = 17;
    localparam int RAW_W     = 16;
    localparam int LIMIT_W   = 20;
    localparam int TILT_W    = 16;
    localparam int DRIVE_W   = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;
    localparam int STATE_W   = 40;
    localparam int CHUNK_W   = 20;
    localparam int OPND_W    = CHUNK_W + 1;
    localparam int PROD_W    = GAIN_W + 1 + OPND_W;
    localparam int ACC_W     = 64;
    localparam int NUM_W     = 44;
    localparam int DIV_BITS  = 4;
    localparam int DIV_STEPS = NUM_W / DIV_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);
    localparam int REM_W     = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BALANCE_KP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BALANCE_KD    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_KP      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_KI      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UPRIGHT_ANGLE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_LIM  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TILT_LIMIT    = 3'd6;

    // register reset values
    localparam logic [GAIN_W-1:0]  RST_BALANCE_KP    = 24'd84480;
    localparam logic [GAIN_W-1:0]  RST_BALANCE_KD    = 24'd261;
    localparam logic [GAIN_W-1:0]  RST_SPEED_KP      = 24'd26880;
    localparam logic [GAIN_W-1:0]  RST_SPEED_KI      = 24'd134;
    localparam logic [ANGLE_W-1:0] RST_UPRIGHT_ANGLE = 17'd0;
    localparam logic [LIMIT_W-1:0] RST_INTEGRAL_LIM  = 20'd10000;
    localparam logic [TILT_W-1:0]  RST_TILT_LIMIT    = 16'd10240;

    // filter divisor
    localparam logic [REM_W:0] DIVISOR = 4'd5;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BAL_P,
        ST_BAL_D,
        ST_BAL_W,
        ST_BAL_R,
        ST_DIV_W,
        ST_INTEG,
        ST_SPD_P0,
        ST_SPD_P1,
        ST_SPD_I0,
        ST_SPD_I1,
        ST_SPD_W,
        ST_SPD_R,
        ST_DONE
    } seq_state_t;

    // weight of a partial product in the accumulator
    typedef enum logic [1:0] {
        MAC_SH_0,
        MAC_SH_8,
        MAC_SH_20
    } mac_shift_t;

    typedef struct packed {
        logic       issue;
        logic       clear;
        mac_shift_t shift;
    } mac_ctrl_t;

    // clamp a wide signed value to the drive range
    function automatic logic signed [DRIVE_W-1:0] sat_drive(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        logic signed [DRIVE_W-1:0] r;
        hi = {{(ACC_W-DRIVE_W+1){1'b0}}, {(DRIVE_W-1){1'b1}}};
        lo = {{(ACC_W-DRIVE_W+1){1'b1}}, {(DRIVE_W-1){1'b0}}};
        if (v > hi)
        begin
            r = hi[DRIVE_W-1:0];
        end
        else if (v < lo)
        begin
            r = lo[DRIVE_W-1:0];
        end
        else
        begin
            r = v[DRIVE_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/bsc_mac.sv
// shared multiply-accumulate unit: registered product, then accumulate
module bsc_mac (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  bsc_pkg::mac_ctrl_t                   ctrl,
    input  logic [bsc_pkg::GAIN_W-1:0]           gain,
    input  logic signed [bsc_pkg::OPND_W-1:0]    operand,
    output logic signed [bsc_pkg::ACC_W-1:0]     acc
);
    import bsc_pkg::*;

    logic signed [GAIN_W:0]   gain_s;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     add_reg;
    logic                     clear_reg;
    mac_shift_t               shift_reg;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  prod_sh;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;

    // product of unsigned gain and signed chunk
    always_comb
    begin
        gain_s = {1'b0, gain};
        prod   = gain_s * operand;
    end

    // product stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            add_reg   <= 1'b0;
            clear_reg <= 1'b0;
            shift_reg <= MAC_SH_0;
        end
        else
        begin
            add_reg   <= ctrl.issue;
            clear_reg <= ctrl.clear;
            shift_reg <= ctrl.shift;
        end
    end

    // product stage data
    always_ff @(posedge clk)
    begin
        if (ctrl.issue)
        begin
            prod_reg <= prod;
        end
    end

    // weight and accumulate
    always_comb
    begin
        prod_ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        unique case (shift_reg)
            MAC_SH_0:  prod_sh = prod_ext;
            MAC_SH_8:  prod_sh = prod_ext <<< 8;
            MAC_SH_20: prod_sh = prod_ext <<< CHUNK_W;
            default:   prod_sh = prod_ext;
        endcase
        acc_next = clear_reg ? prod_sh : (acc_reg + prod_sh);
    end

    always_ff @(posedge clk)
    begin
        if (add_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

FILE: rtl/core/bsc_div5.sv
// signed divide by five, truncating toward zero, four quotient bits a cycle
module bsc_div5 (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [bsc_pkg::NUM_W-1:0]     num,
    output logic                                 busy,
    output logic signed [bsc_pkg::STATE_W-1:0]   quo
);
    import bsc_pkg::*;

    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic                 neg_reg;
    logic [NUM_W-1:0]     mag_reg;
    logic [NUM_W-1:0]     mag_next;
    logic [REM_W-1:0]     rem_reg;
    logic [REM_W-1:0]     rem_next;
    logic [REM_W:0]       trial;
    logic [NUM_W-1:0]     quo_mag;

    // four restoring steps on the shifting dividend
    always_comb
    begin
        mag_next = mag_reg;
        rem_next = rem_reg;
        trial    = '0;
        for (int k = 0; k < DIV_BITS; k++)
        begin
            trial    = {rem_next, mag_next[NUM_W-1]};
            mag_next = {mag_next[NUM_W-2:0], 1'b0};
            if (trial >= DIVISOR)
            begin
                rem_next    = REM_W'(trial - DIVISOR);
                mag_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial[REM_W-1:0];
            end
        end
        cnt_next = cnt_reg - DIV_CNT_W'(1);
    end

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CNT_W'(DIV_STEPS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_next;
            if (cnt_next == '0)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // dividend, quotient and remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[NUM_W-1];
            mag_reg <= num[NUM_W-1] ? (NUM_W'(0) - NUM_W'(num)) : NUM_W'(num);
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            mag_reg <= mag_next;
            rem_reg <= rem_next;
        end
    end

    // apply the sign to the magnitude quotient
    always_comb
    begin
        quo_mag = neg_reg ? (NUM_W'(0) - mag_reg) : mag_reg;
        quo     = quo_mag[STATE_W-1:0];
    end

    assign busy = busy_reg;

endmodule

FILE: rtl/core/balance_and_speed_cascade.sv
// top level: balance PD and speed PI cascade with a shared multiplier
//
// Takes one sensor item, returns one drive item. After acceptance the divide
// by five of the speed filter runs four quotient bits a cycle (started at
// acceptance, alongside the two balance products), then the four speed
// partial products pass one a cycle through the single 25x21 multiplier,
// which has a product register and an accumulator register in its path.
// A new item is taken once the result has moved into the output register, so
// a waiting result does not hold back the next item's work. Balance and speed
// terms are truncated toward zero and saturated to 24 bits; motor_drive is the
// saturated sum of the two. The integral is cleared after the item when
// |pitch_angle| exceeds tilt_limit.
module balance_and_speed_cascade (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // sensor items
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [bsc_pkg::ANGLE_W-1:0]    roll_angle,
    input  logic signed [bsc_pkg::ANGLE_W-1:0]    pitch_angle,
    input  logic signed [bsc_pkg::RAW_W-1:0]      gyro_rate,
    input  logic signed [bsc_pkg::RAW_W-1:0]      left_count,
    input  logic signed [bsc_pkg::RAW_W-1:0]      right_count,
    input  logic signed [bsc_pkg::RAW_W-1:0]      target_speed,
    // drive items
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [bsc_pkg::DRIVE_W-1:0]    balance_drive,
    output logic signed [bsc_pkg::DRIVE_W-1:0]    speed_drive,
    output logic signed [bsc_pkg::DRIVE_W-1:0]    motor_drive,
    output logic                                  integral_cleared,
    // register writes
    input  logic                                  cfg_we,
    input  logic [bsc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [bsc_pkg::CFG_DAT_W-1:0]         cfg_data
);
    import bsc_pkg::*;

    localparam int BAL_SH = 16;
    localparam int SPD_SH = 24;
    localparam logic signed [ACC_W-1:0] BAL_ROUND = ACC_W'((64'd1 << BAL_SH) - 64'd1);
    localparam logic signed [ACC_W-1:0] SPD_ROUND = ACC_W'((64'd1 << SPD_SH) - 64'd1);

    // configuration registers
    logic [GAIN_W-1:0]  bal_kp_reg;
    logic [GAIN_W-1:0]  bal_kd_reg;
    logic [GAIN_W-1:0]  spd_kp_reg;
    logic [GAIN_W-1:0]  spd_ki_reg;
    logic [ANGLE_W-1:0] upright_reg;
    logic [LIMIT_W-1:0] int_lim_reg;
    logic [TILT_W-1:0]  tilt_reg;

    // sequencer and item state
    seq_state_t               state_reg;
    seq_state_t               state_next;
    logic signed [ANGLE_W:0]  bias_reg;
    logic signed [RAW_W-1:0]  gyro_reg;
    logic                     clear_reg;
    logic signed [STATE_W-1:0] fe_reg;
    logic signed [STATE_W-1:0] int_reg;
    logic signed [DRIVE_W-1:0] bal_reg;
    logic signed [DRIVE_W-1:0] spd_reg;

    // output register
    logic                      out_valid_reg;
    logic signed [DRIVE_W-1:0] bal_out_reg;
    logic signed [DRIVE_W-1:0] spd_out_reg;
    logic signed [DRIVE_W-1:0] mot_out_reg;
    logic                      clr_out_reg;

    // datapath signals
    logic                      accept;
    logic                      out_free;
    logic signed [ANGLE_W:0]   bias_in;
    logic signed [ANGLE_W:0]   pitch_ext;
    logic signed [ANGLE_W:0]   tilt_ext;
    logic                      clear_in;
    logic signed [RAW_W+1:0]   err;
    logic signed [NUM_W-1:0]   num;
    logic                      div_busy;
    logic signed [STATE_W-1:0] div_quo;
    logic signed [STATE_W:0]   int_sum;
    logic signed [STATE_W:0]   int_lim;
    logic signed [STATE_W-1:0] int_clamped;
    mac_ctrl_t                 mac_ctrl;
    logic [GAIN_W-1:0]         mac_gain;
    logic signed [OPND_W-1:0]  mac_opnd;
    logic signed [ACC_W-1:0]   acc;
    logic signed [ACC_W-1:0]   bal_tz;
    logic signed [ACC_W-1:0]   spd_tz;
    logic signed [ACC_W-1:0]   mot_sum;

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // register writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bal_kp_reg  <= RST_BALANCE_KP;
            bal_kd_reg  <= RST_BALANCE_KD;
            spd_kp_reg  <= RST_SPEED_KP;
            spd_ki_reg  <= RST_SPEED_KI;
            upright_reg <= RST_UPRIGHT_ANGLE;
            int_lim_reg <= RST_INTEGRAL_LIM;
            tilt_reg    <= RST_TILT_LIMIT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BALANCE_KP:    bal_kp_reg  <= cfg_data[GAIN_W-1:0];
                CFG_BALANCE_KD:    bal_kd_reg  <= cfg_data[GAIN_W-1:0];
                CFG_SPEED_KP:      spd_kp_reg  <= cfg_data[GAIN_W-1:0];
                CFG_SPEED_KI:      spd_ki_reg  <= cfg_data[GAIN_W-1:0];
                CFG_UPRIGHT_ANGLE: upright_reg <= cfg_data[ANGLE_W-1:0];
                CFG_INTEGRAL_LIM:  int_lim_reg <= cfg_data[LIMIT_W-1:0];
                CFG_TILT_LIMIT:    tilt_reg    <= cfg_data[TILT_W-1:0];
                default:           ;
            endcase
        end
    end

    // input conditioning at acceptance
    always_comb
    begin
        bias_in   = {roll_angle[ANGLE_W-1], roll_angle}
                  - {upright_reg[ANGLE_W-1], upright_reg};
        pitch_ext = {pitch_angle[ANGLE_W-1], pitch_angle};
        tilt_ext  = {{(ANGLE_W+1-TILT_W){1'b0}}, tilt_reg};
        clear_in  = (pitch_ext > tilt_ext) || (pitch_ext < -tilt_ext);
        err       = {{2{left_count[RAW_W-1]}}, left_count}
                  + {{2{right_count[RAW_W-1]}}, right_count}
                  - {{2{target_speed[RAW_W-1]}}, target_speed};
        num       = {{2{fe_reg[STATE_W-1]}}, fe_reg, 2'b00}
                  + {{(NUM_W-RAW_W-2-16){err[RAW_W+1]}}, err, 16'b0};
    end

    // filter divide, started with the item
    bsc_div5 u_div5 (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .num   (num),
        .busy  (div_busy),
        .quo   (div_quo)
    );

    // shared multiplier
    bsc_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mac_ctrl),
        .gain    (mac_gain),
        .operand (mac_opnd),
        .acc     (acc)
    );

    // integral update with symmetric clamp
    always_comb
    begin
        int_sum = {int_reg[STATE_W-1], int_reg} + {div_quo[STATE_W-1], div_quo};
        int_lim = {{(STATE_W+1-LIMIT_W-16){1'b0}}, int_lim_reg, 16'b0};
        if (int_sum > int_lim)
        begin
            int_clamped = int_lim[STATE_W-1:0];
        end
        else if (int_sum < -int_lim)
        begin
            int_clamped = STATE_W'(-int_lim);
        end
        else
        begin
            int_clamped = int_sum[STATE_W-1:0];
        end
    end

    // truncation toward zero of the accumulated terms, and the motor sum
    always_comb
    begin
        bal_tz  = acc[ACC_W-1] ? ((acc + BAL_ROUND) >>> BAL_SH) : (acc >>> BAL_SH);
        spd_tz  = acc[ACC_W-1] ? ((acc + SPD_ROUND) >>> SPD_SH) : (acc >>> SPD_SH);
        mot_sum = {{(ACC_W-DRIVE_W){bal_reg[DRIVE_W-1]}}, bal_reg}
                + {{(ACC_W-DRIVE_W){spd_reg[DRIVE_W-1]}}, spd_reg};
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_BAL_P;
            ST_BAL_P:  state_next = ST_BAL_D;
            ST_BAL_D:  state_next = ST_BAL_W;
            ST_BAL_W:  state_next = ST_BAL_R;
            ST_BAL_R:  state_next = ST_DIV_W;
            ST_DIV_W:  if (!div_busy) state_next = ST_INTEG;
            ST_INTEG:  state_next = ST_SPD_P0;
            ST_SPD_P0: state_next = ST_SPD_P1;
            ST_SPD_P1: state_next = ST_SPD_I0;
            ST_SPD_I0: state_next = ST_SPD_I1;
            ST_SPD_I1: state_next = ST_SPD_W;
            ST_SPD_W:  state_next = ST_SPD_R;
            ST_SPD_R:  state_next = ST_DONE;
            ST_DONE:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // sequencer outputs: handshake and multiplier operand selection
    always_comb
    begin
        in_ready       = 1'b0;
        mac_ctrl.issue = 1'b0;
        mac_ctrl.clear = 1'b0;
        mac_ctrl.shift = MAC_SH_0;
        mac_gain       = bal_kp_reg;
        mac_opnd       = {{(OPND_W-ANGLE_W-1){bias_reg[ANGLE_W]}}, bias_reg};
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_BAL_P:
            begin
                mac_ctrl.issue = 1'b1;
                mac_ctrl.clear = 1'b1;
            end
            ST_BAL_D:
            begin
                mac_ctrl.issue = 1'b1;
                mac_ctrl.shift = MAC_SH_8;
                mac_gain       = bal_kd_reg;
                mac_opnd       = {{(OPND_W-RAW_W){gyro_reg[RAW_W-1]}}, gyro_reg};
            end
            ST_SPD_P0:
            begin
                mac_ctrl.issue = 1'b1;
                mac_ctrl.clear = 1'b1;
                mac_gain       = spd_kp_reg;
                mac_opnd       = {1'b0, fe_reg[CHUNK_W-1:0]};
            end
            ST_SPD_P1:
            begin
                mac_ctrl.issue = 1'b1;
                mac_ctrl.shift = MAC_SH_20;
                mac_gain       = spd_kp_reg;
                mac_opnd       = {fe_reg[STATE_W-1], fe_reg[STATE_W-1:CHUNK_W]};
            end
            ST_SPD_I0:
            begin
                mac_ctrl.issue = 1'b1;
                mac_gain       = spd_ki_reg;
                mac_opnd       = {1'b0, int_reg[CHUNK_W-1:0]};
            end
            ST_SPD_I1:
            begin
                mac_ctrl.issue = 1'b1;
                mac_ctrl.shift = MAC_SH_20;
                mac_gain       = spd_ki_reg;
                mac_opnd       = {int_reg[STATE_W-1], int_reg[STATE_W-1:CHUNK_W]};
            end
            default:
            begin
            end
        endcase
    end

    // filter and integral state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fe_reg  <= '0;
            int_reg <= '0;
        end
        else if (state_reg == ST_INTEG)
        begin
            fe_reg  <= div_quo;
            int_reg <= int_clamped;
        end
        else if (state_reg == ST_DONE && out_free && clear_reg)
        begin
            int_reg <= '0;
        end
    end

    // item fields and intermediate terms
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bias_reg  <= bias_in;
            gyro_reg  <= gyro_rate;
            clear_reg <= clear_in;
        end
        if (state_reg == ST_BAL_R)
        begin
            bal_reg <= sat_drive(bal_tz);
        end
        if (state_reg == ST_SPD_R)
        begin
            spd_reg <= sat_drive(spd_tz);
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_DONE && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && out_free)
        begin
            bal_out_reg <= bal_reg;
            spd_out_reg <= spd_reg;
            mot_out_reg <= sat_drive(mot_sum);
            clr_out_reg <= clear_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign balance_drive    = bal_out_reg;
    assign speed_drive      = spd_out_reg;
    assign motor_drive      = mot_out_reg;
    assign integral_cleared = clr_out_reg;

endmodule

FILE: verif/balance_and_speed_cascade_test.sv
`timescale 1ns / 1ps
// self-checking testbench for the balance and speed cascade
module balance_and_speed_cascade_test;

    import bsc_pkg::*;

    // register index that maps to no register
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    localparam longint Q16_SCALE = 64'sd65536;
    localparam longint Q24_SCALE = 64'sd16777216;
    localparam longint DRIVE_HI  = 64'sd8388607;
    localparam longint DRIVE_LO  = -64'sd8388608;

    typedef struct packed {
        logic [ANGLE_W-1:0] roll;
        logic [ANGLE_W-1:0] pitch;
        logic [RAW_W-1:0]   gyro;
        logic [RAW_W-1:0]   left;
        logic [RAW_W-1:0]   right;
        logic [RAW_W-1:0]   target;
    } sensor_t;

    typedef struct packed {
        logic [DRIVE_W-1:0] balance;
        logic [DRIVE_W-1:0] speed;
        logic [DRIVE_W-1:0] motor;
        logic               cleared;
    } drive_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [ANGLE_W-1:0]    roll_angle;
    logic [ANGLE_W-1:0]    pitch_angle;
    logic [RAW_W-1:0]      gyro_rate;
    logic [RAW_W-1:0]      left_count;
    logic [RAW_W-1:0]      right_count;
    logic [RAW_W-1:0]      target_speed;
    logic                  out_valid;
    logic                  out_ready;
    logic [DRIVE_W-1:0]    balance_drive;
    logic [DRIVE_W-1:0]    speed_drive;
    logic [DRIVE_W-1:0]    motor_drive;
    logic                  integral_cleared;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DAT_W-1:0]  cfg_data;

    // sensor items waiting to be sent, drive items waiting to arrive
    sensor_t sensor_q[$];
    drive_t  drive_q[$];
    sensor_t offered;
    bit      offer_taken;
    int      fail_count;
    int      src_idle_pct;
    int      sink_idle_pct;

    // predictor copy of the registers and the loop state
    logic [GAIN_W-1:0]  gain_bal_p;
    logic [GAIN_W-1:0]  gain_bal_d;
    logic [GAIN_W-1:0]  gain_spd_p;
    logic [GAIN_W-1:0]  gain_spd_i;
    logic [ANGLE_W-1:0] upright;
    logic [LIMIT_W-1:0] integ_lim;
    logic [TILT_W-1:0]  tilt_lim;
    longint             filt_err;
    longint             integ_acc;

    balance_and_speed_cascade dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .roll_angle       (roll_angle),
        .pitch_angle      (pitch_angle),
        .gyro_rate        (gyro_rate),
        .left_count       (left_count),
        .right_count      (right_count),
        .target_speed     (target_speed),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .balance_drive    (balance_drive),
        .speed_drive      (speed_drive),
        .motor_drive      (motor_drive),
        .integral_cleared (integral_cleared),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic longint clamp_drive(input longint v);
        if (v > DRIVE_HI)
        begin
            return DRIVE_HI;
        end
        if (v < DRIVE_LO)
        begin
            return DRIVE_LO;
        end
        return v;
    endfunction

    // one control tick: balance pd, filtered speed pi, integral clear on tilt
    function automatic drive_t predict_drive(input sensor_t s);
        longint roll_v;
        longint pitch_v;
        longint gyro_v;
        longint err;
        longint lean;
        longint lim;
        longint tilt;
        longint bal;
        longint spd;
        longint mot;
        longint kp_b;
        longint kd_b;
        longint kp_s;
        longint ki_s;
        drive_t d;
        roll_v  = $signed(s.roll);
        pitch_v = $signed(s.pitch);
        gyro_v  = $signed(s.gyro);
        err     = $signed(s.left);
        err     = err + longint'($signed(s.right)) - longint'($signed(s.target));
        lean    = roll_v - longint'($signed(upright));
        kp_b    = gain_bal_p;
        kd_b    = gain_bal_d;
        kp_s    = gain_spd_p;
        ki_s    = gain_spd_i;
        lim     = integ_lim;
        lim     = lim * Q16_SCALE;
        tilt    = tilt_lim;

        bal = clamp_drive((kp_b * lean + kd_b * gyro_v * 256) / Q16_SCALE);

        // low-pass filter and clamped integral
        filt_err  = (4 * filt_err + err * Q16_SCALE) / 5;
        integ_acc = integ_acc + filt_err;
        if (integ_acc > lim)
        begin
            integ_acc = lim;
        end
        if (integ_acc < -lim)
        begin
            integ_acc = -lim;
        end

        spd = clamp_drive((kp_s * filt_err + ki_s * integ_acc) / Q24_SCALE);
        mot = clamp_drive(bal + spd);

        d.cleared = (pitch_v > tilt) || (pitch_v < -tilt);
        if (d.cleared)
        begin
            integ_acc = 0;
        end
        d.balance = bal[DRIVE_W-1:0];
        d.speed   = spd[DRIVE_W-1:0];
        d.motor   = mot[DRIVE_W-1:0];
        return d;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("%t %s", $realtime, msg);
        end
    endtask

    // sender: take the item on the handshake and predict its result
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            drive_q.push_back(predict_drive(offered));
            offer_taken = 1'b1;
        end
    end

    // sender: offer the next item at the falling edge, with random gaps
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || offer_taken)
        begin
            offer_taken = 1'b0;
            if (sensor_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct)
            begin
                offered = sensor_q.pop_front();
                in_valid     <= 1'b1;
                roll_angle   <= offered.roll;
                pitch_angle  <= offered.pitch;
                gyro_rate    <= offered.gyro;
                left_count   <= offered.left;
                right_count  <= offered.right;
                target_speed <= offered.target;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // receiver: compare each drive item with the oldest prediction
    always @(posedge clk)
    begin : check_drive
        drive_t got;
        drive_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got.balance = balance_drive;
            got.speed   = speed_drive;
            got.motor   = motor_drive;
            got.cleared = integral_cleared;
            if (drive_q.size() == 0)
            begin
                note_failure($sformatf("unexpected item: bal %0d spd %0d mot %0d clr %0d",
                    $signed(got.balance), $signed(got.speed), $signed(got.motor),
                    got.cleared));
            end
            else
            begin
                want = drive_q.pop_front();
                if (got !== want)
                begin
                    note_failure($sformatf(
                        "mismatch: bal %0d/%0d spd %0d/%0d mot %0d/%0d clr %0d/%0d",
                        $signed(want.balance), $signed(got.balance),
                        $signed(want.speed), $signed(got.speed),
                        $signed(want.motor), $signed(got.motor),
                        want.cleared, got.cleared));
                end
            end
        end
    end

    // register write, mirrored into the predictor
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_BALANCE_KP:    gain_bal_p = val[GAIN_W-1:0];
            CFG_BALANCE_KD:    gain_bal_d = val[GAIN_W-1:0];
            CFG_SPEED_KP:      gain_spd_p = val[GAIN_W-1:0];
            CFG_SPEED_KI:      gain_spd_i = val[GAIN_W-1:0];
            CFG_UPRIGHT_ANGLE: upright    = val[ANGLE_W-1:0];
            CFG_INTEGRAL_LIM:  integ_lim  = val[LIMIT_W-1:0];
            CFG_TILT_LIMIT:    tilt_lim   = val[TILT_W-1:0];
            default:           ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [CFG_DAT_W-1:0] pick_cfg(input logic [CFG_DAT_W-1:0] lo,
                                                      input logic [CFG_DAT_W-1:0] hi,
                                                      input logic [CFG_DAT_W-1:0] dflt,
                                                      input logic [CFG_DAT_W-1:0] rnd);
        case ($urandom_range(0, 4))
            0:       return lo;
            1:       return hi;
            2:       return dflt;
            default: return rnd;
        endcase
    endfunction

    function automatic logic [CFG_DAT_W-1:0] rand_gain();
        logic [31:0] r;
        r = $urandom();
        if ($urandom_range(0, 2) == 0)
        begin
            return r[CFG_DAT_W-1:0];
        end
        return CFG_DAT_W'($urandom_range(0, 100000));
    endfunction

    // new random setting for every register, plus an ignored write
    task automatic randomize_regs();
        logic [31:0] r;
        r = $urandom();
        write_reg(CFG_BALANCE_KP, pick_cfg(0, 24'hFFFFFF, RST_BALANCE_KP, rand_gain()));
        write_reg(CFG_BALANCE_KD, pick_cfg(0, 24'hFFFFFF, RST_BALANCE_KD, rand_gain()));
        write_reg(CFG_SPEED_KP, pick_cfg(0, 24'hFFFFFF, RST_SPEED_KP, rand_gain()));
        write_reg(CFG_SPEED_KI, pick_cfg(0, 24'hFFFFFF, RST_SPEED_KI, rand_gain()));
        write_reg(CFG_UPRIGHT_ANGLE, pick_cfg(24'h010000, 24'h00FFFF, RST_UPRIGHT_ANGLE,
            r[CFG_DAT_W-1:0]));
        write_reg(CFG_INTEGRAL_LIM, pick_cfg(0, 24'hFFFFFF, RST_INTEGRAL_LIM,
            CFG_DAT_W'($urandom_range(0, 3000))));
        write_reg(CFG_TILT_LIMIT, pick_cfg(0, 24'h00FFFF, RST_TILT_LIMIT,
            CFG_DAT_W'($urandom_range(0, 46080))));
        r = $urandom();
        write_reg(CFG_UNUSED, r[CFG_DAT_W-1:0]);
    endtask

    task automatic add_item(input int roll, input int pitch, input int gyro,
                            input int left, input int right, input int target);
        sensor_t s;
        s.roll   = ANGLE_W'(roll);
        s.pitch  = ANGLE_W'(pitch);
        s.gyro   = RAW_W'(gyro);
        s.left   = RAW_W'(left);
        s.right  = RAW_W'(right);
        s.target = RAW_W'(target);
        sensor_q.push_back(s);
    endtask

    // noise item with all bits random, or a steady tick around a speed bias
    task automatic add_random_item(input bit noisy, input int bias);
        logic [31:0] r1;
        logic [31:0] r2;
        logic [31:0] r3;
        int          t;
        int          p;
        r1 = $urandom();
        r2 = $urandom();
        r3 = $urandom();
        if (noisy)
        begin
            add_item(int'(r1[ANGLE_W-1:0]), int'(r2[ANGLE_W-1:0]), int'(r3[RAW_W-1:0]),
                int'(r1[31:16]), int'(r2[31:16]), int'(r3[31:16]));
        end
        else
        begin
            t = int'(tilt_lim);
            case ($urandom_range(0, 11))
                0:       p = t;
                1:       p = -t;
                2:       p = t + 1;
                3:       p = -t - 1;
                4:       p = int'($urandom_range(0, 92160)) - 46080;
                default: p = int'($urandom_range(0, 2 * t)) - t;
            endcase
            add_item(int'($urandom_range(0, 92160)) - 46080, p, int'(r3[RAW_W-1:0]),
                bias / 2 + int'($urandom_range(0, 100)) - 50,
                bias / 2 + int'($urandom_range(0, 100)) - 50,
                int'($urandom_range(0, 400)) - 200);
        end
    endtask

    task automatic wait_drained();
        while (sensor_q.size() != 0 || in_valid || drive_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // stimulus
    initial
    begin
        int phase;
        int half;
        int count;
        int burst;
        int bias;
        bit noisy;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        out_ready    = 1'b0;
        roll_angle   = '0;
        pitch_angle  = '0;
        gyro_rate    = '0;
        left_count   = '0;
        right_count  = '0;
        target_speed = '0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        offer_taken  = 1'b0;
        fail_count   = 0;
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        gain_bal_p = RST_BALANCE_KP;
        gain_bal_d = RST_BALANCE_KD;
        gain_spd_p = RST_SPEED_KP;
        gain_spd_i = RST_SPEED_KI;
        upright    = RST_UPRIGHT_ANGLE;
        integ_lim  = RST_INTEGRAL_LIM;
        tilt_lim   = RST_TILT_LIMIT;
        filt_err   = 0;
        integ_acc  = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // reset setting: field extremes, integral clamp, tilt at and past the limit
        add_item(0, 0, 0, 0, 0, 0);
        add_item(46080, 10240, 32767, 32767, 32767, -32768);
        add_item(46080, 0, 32767, 32767, 32767, -32768);
        add_item(-46080, -10240, -32768, -32768, -32768, 32767);
        add_item(-46080, 10241, -32768, -32768, -32768, 32767);
        add_item(65535, -10241, 0, 100, 100, 0);
        add_item(-65536, -65536, 0, 0, 0, 0);
        add_item(0, 65535, 0, 1, 0, 0);
        wait_drained();

        // top gains, lowest upright angle, zero tilt limit, ignored index
        write_reg(CFG_BALANCE_KP, 24'hFFFFFF);
        write_reg(CFG_BALANCE_KD, 24'hFFFFFF);
        write_reg(CFG_SPEED_KP, 24'hFFFFFF);
        write_reg(CFG_SPEED_KI, 24'hFFFFFF);
        write_reg(CFG_UPRIGHT_ANGLE, 24'h010000);
        write_reg(CFG_INTEGRAL_LIM, 24'hFFFFFF);
        write_reg(CFG_TILT_LIMIT, 24'h000000);
        write_reg(CFG_UNUSED, 24'hABCDEF);
        add_item(0, 0, 0, 0, 0, 0);
        add_item(65535, 1, 32767, 32767, 32767, -32768);
        add_item(-65536, -1, -32768, -32768, -32768, 32767);
        add_item(0, 0, -32768, -32768, -32768, 32767);
        wait_drained();

        // terms that fit alone but overflow as a sum
        write_reg(CFG_BALANCE_KP, 24'd8000000);
        write_reg(CFG_BALANCE_KD, 24'd0);
        write_reg(CFG_SPEED_KI, 24'd0);
        write_reg(CFG_UPRIGHT_ANGLE, 24'd0);
        write_reg(CFG_INTEGRAL_LIM, 24'd0);
        write_reg(CFG_TILT_LIMIT, 24'd46080);
        add_item(65535, 0, 0, 32767, 32767, -32768);
        add_item(-65536, 0, 0, -32768, -32768, 32767);
        add_item(46080, 46080, 0, 0, 0, 0);
        add_item(0, 46081, 0, 0, 0, 0);
        wait_drained();

        // random ticks in bursts of steady speed error, under each idling mix
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
                1:
                begin
                    src_idle_pct  = 69;
                    sink_idle_pct = 0;
                end
                2:
                begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 69;
                end
                default:
                begin
                    src_idle_pct  = 8;
                    sink_idle_pct = 8;
                end
            endcase
            for (half = 0; half < 2; half++)
            begin
                randomize_regs();
                count = 0;
                while (count < 50)
                begin
                    burst = $urandom_range(1, 20);
                    bias  = int'($urandom_range(0, 32000)) - 16000;
                    noisy = ($urandom_range(0, 4) == 0);
                    repeat (burst)
                    begin
                        add_random_item(noisy, bias);
                        count++;
                    end
                end
                wait_drained();
            end
        end

        repeat (60) @(posedge clk);
        while (drive_q.size() != 0)
        begin
            void'(drive_q.pop_front());
            note_failure("drive item never arrived");
        end
        if (fail_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // run limit
    initial
    begin
        #5000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
